// File: hdl/rrg_pkg.sv
// Shared types and constants for the RFID reply gate.
`default_nettype none
package rrg_pkg;
    localparam int AMP_WIN_DEF     = 64;
    localparam int DC_WIN_DEF      = 32;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int IN_BITS         = 16;
    localparam int OUT_BITS        = 17;
    localparam int MAG_BITS        = 33;
    localparam int CNT_BITS        = 16;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 16;
    localparam int IN_TDATA_BITS   = 32;
    localparam int OUT_TDATA_BITS  = 72;

    localparam logic [1:0] OP_SAMPLE   = 2'd0;
    localparam logic [1:0] OP_SEEK_RN  = 2'd1;
    localparam logic [1:0] OP_SEEK_EPC = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_T1     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PW     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_THR    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MINP   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_RN16   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_EPC    = 3'd6;

    // Queue entry between front and back.
    typedef struct packed {
        logic                        is_seek;
        logic                        seek_epc;
        logic signed [IN_BITS-1:0]   si;
        logic signed [IN_BITS-1:0]   sq;
    } rrg_cmd_t;
endpackage
`default_nettype wire

// File: hdl/rrg_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module rrg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hdl/rrg_front.sv
// Front end: accept requests, classify, drop disabled or undefined ones, queue the rest.
`default_nettype none
module rrg_front
    import rrg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               in_op,
    input  wire logic [IN_BITS-1:0]       in_i,
    input  wire logic [IN_BITS-1:0]       in_q,
    input  wire logic                     enable,
    output logic                          q_valid,
    input  wire logic                     q_pop,
    output rrg_cmd_t                      q_head
);
    localparam int QD = 2;
    rrg_cmd_t   fifo_reg [QD];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    rrg_cmd_t   c;

    assign in_ready = (cnt_reg != 2'(QD));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_head   = fifo_reg[rp_reg];

    always_comb
    begin
        c.is_seek  = (in_op == OP_SEEK_RN) || (in_op == OP_SEEK_EPC);
        c.seek_epc = (in_op == OP_SEEK_EPC);
        // Sign-extend from SAMPLE_BITS.
        c.si = IN_BITS'($signed(in_i[SAMPLE_BITS-1:0]));
        c.sq = IN_BITS'($signed(in_q[SAMPLE_BITS-1:0]));
        push = in_valid && in_ready && (c.is_seek || (in_op == OP_SAMPLE && enable));
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wp_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule
`default_nettype wire

// File: hdl/rrg_back.sv
// Back end: square root, ring updates, edge and gate logic, result register.
`default_nettype none
module rrg_back
    import rrg_pkg::*;
#(
    parameter int AMP_WIN = AMP_WIN_DEF,
    parameter int DC_WIN  = DC_WIN_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    output logic                            q_pop,
    input  wire rrg_cmd_t                   q_head,
    input  wire logic [15:0]                t1_samples,
    input  wire logic [11:0]                pulse_width_samples,
    input  wire logic [7:0]                 thresh_frac,
    input  wire logic [7:0]                 min_pulses,
    input  wire logic [15:0]                rn16_window_samples,
    input  wire logic [15:0]                epc_window_samples,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [OUT_BITS-1:0]      out_i,
    output logic signed [OUT_BITS-1:0]      out_q,
    output logic [MAG_BITS-1:0]             magn_sq,
    output logic                            last
);
    localparam int AW  = (AMP_WIN > 1) ? $clog2(AMP_WIN) : 1;
    localparam int DW  = (DC_WIN > 1) ? $clog2(DC_WIN) : 1;
    localparam int ASB = 17 + AW;
    localparam int DSB = IN_BITS + DW;
    localparam int AFW = ((AMP_WIN > 256) ? AMP_WIN : 256);
    localparam int AFB = $clog2(AFW + 1);
    localparam int DFW = ((DC_WIN > 256) ? DC_WIN : 256);
    localparam int DFB = $clog2(DFW + 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SQ   = 7'b0000010,
        ST_SQRT = 7'b0000100,
        ST_RD   = 7'b0001000,
        ST_UPD  = 7'b0010000,
        ST_MUL  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } st_t;

    st_t st_reg;
    logic signed [IN_BITS-1:0] si_reg, sq_reg;
    logic [32:0] x_reg;
    logic [32:0] r_reg;
    logic [32:0] bit_reg;
    logic [16:0] ampl_reg;
    logic [ASB-1:0] amp_sum_reg;
    logic [AW-1:0]  amp_pos_reg;
    logic [AFB-1:0] amp_fill_reg;
    logic signed [DSB-1:0] dc_sum_i_reg, dc_sum_q_reg;
    logic [DW-1:0]  dc_pos_reg;
    logic [DFB-1:0] dc_fill_reg;
    logic [15:0] sample_count_reg, ungate_target_reg;
    logic [7:0]  pulse_count_reg;
    logic level_high_reg, gate_open_reg;
    logic signed [OUT_BITS-1:0] ci_reg, cq_reg;
    logic emit_last_reg;
    logic signed [OUT_BITS-1:0] oi_reg, oq_reg;
    logic [MAG_BITS-1:0] om_reg;
    logic ol_reg, ov_reg;
    logic [ASB+7:0] thr8_reg;

    // rings
    logic [16:0] amp_old;
    logic [2*IN_BITS-1:0] dc_old;
    logic amp_old_ok, dc_old_ok;
    logic amp_we, dc_we;

    rrg_ram #(.WIDTH(17), .DEPTH(AMP_WIN)) u_amp (
        .clk(clk), .we(amp_we), .waddr(amp_pos_reg), .wdata(ampl_reg),
        .raddr(amp_pos_reg), .rdata(amp_old)
    );
    rrg_ram #(.WIDTH(2*IN_BITS), .DEPTH(DC_WIN)) u_dc (
        .clk(clk), .we(dc_we), .waddr(dc_pos_reg), .wdata({sq_reg, si_reg}),
        .raddr(dc_pos_reg), .rdata(dc_old)
    );

    assign amp_old_ok = (amp_fill_reg >= AFB'(AMP_WIN));
    assign dc_old_ok  = (dc_fill_reg >= DFB'(DC_WIN));
    assign amp_we = (st_reg == ST_UPD);
    assign dc_we  = (st_reg == ST_UPD) && !gate_open_reg;

    assign q_pop     = (st_reg == ST_IDLE) && q_valid;
    assign out_valid = ov_reg;
    assign out_i     = oi_reg;
    assign out_q     = oq_reg;
    assign magn_sq   = om_reg;
    assign last      = ol_reg;

    logic [ASB-1:0] amp_sum_n;
    logic signed [DSB-1:0] dsi_n, dsq_n;
    logic [15:0] sc_inc;
    logic [ASB+7:0] a8;
    logic [33:0] trial;

    always_comb
    begin
        amp_sum_n = amp_sum_reg - (amp_old_ok ? ASB'(amp_old) : ASB'(0)) + ASB'(ampl_reg);
        dsi_n = dc_sum_i_reg - (dc_old_ok ? DSB'($signed(dc_old[IN_BITS-1:0])) : DSB'(0))
                + DSB'(si_reg);
        dsq_n = dc_sum_q_reg
                - (dc_old_ok ? DSB'($signed(dc_old[2*IN_BITS-1:IN_BITS])) : DSB'(0))
                + DSB'(sq_reg);
        sc_inc = (sample_count_reg == 16'hFFFF) ? sample_count_reg : sample_count_reg + 16'd1;
        a8 = (ASB+8)'({ampl_reg, 8'd0});
        trial = {1'b0, r_reg} + {1'b0, bit_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            amp_sum_reg <= '0; amp_pos_reg <= '0; amp_fill_reg <= '0;
            dc_sum_i_reg <= '0; dc_sum_q_reg <= '0; dc_pos_reg <= '0; dc_fill_reg <= '0;
            sample_count_reg <= '0; pulse_count_reg <= '0;
            level_high_reg <= 1'b0; gate_open_reg <= 1'b0; ungate_target_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            // ST_OUT reloads the result register itself when it is taken
            if (ov_reg && out_ready && st_reg != ST_OUT)
            begin
                ov_reg <= 1'b0;
            end
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_head.is_seek)
                        begin
                            gate_open_reg <= 1'b0;
                            sample_count_reg <= '0;
                            ungate_target_reg <= q_head.seek_epc ? epc_window_samples
                                                                 : rn16_window_samples;
                        end
                        else
                        begin
                            si_reg <= q_head.si;
                            sq_reg <= q_head.sq;
                            st_reg <= ST_SQ;
                        end
                    end
                end
                ST_SQ:
                begin
                    x_reg <= 33'(32'($signed(si_reg) * $signed(si_reg)))
                           + 33'(32'($signed(sq_reg) * $signed(sq_reg)));
                    r_reg <= '0;
                    bit_reg <= 33'h1 << 32;
                    st_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    // one result bit per cycle
                    if (bit_reg == '0)
                    begin
                        ampl_reg <= r_reg[16:0];
                        st_reg <= ST_RD;
                    end
                    else
                    begin
                        if ({1'b0, x_reg} >= trial)
                        begin
                            x_reg <= x_reg - trial[32:0];
                            r_reg <= (r_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            r_reg <= r_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                ST_RD:
                begin
                    st_reg <= ST_UPD; // ring read data settles
                end
                ST_UPD:
                begin
                    amp_sum_reg <= amp_sum_n;
                    amp_pos_reg <= (amp_pos_reg == AW'(AMP_WIN-1)) ? '0 : amp_pos_reg + 1'b1;
                    if (!amp_old_ok) amp_fill_reg <= amp_fill_reg + 1'b1;
                    if (!gate_open_reg)
                    begin
                        dc_sum_i_reg <= dsi_n;
                        dc_sum_q_reg <= dsq_n;
                        dc_pos_reg <= (dc_pos_reg == DW'(DC_WIN-1)) ? '0 : dc_pos_reg + 1'b1;
                        if (!dc_old_ok) dc_fill_reg <= dc_fill_reg + 1'b1;
                        ci_reg <= OUT_BITS'(si_reg) - OUT_BITS'(dsi_n >>> DW);
                        cq_reg <= OUT_BITS'(sq_reg) - OUT_BITS'(dsq_n >>> DW);
                    end
                    else
                    begin
                        ci_reg <= OUT_BITS'(si_reg) - OUT_BITS'(dc_sum_i_reg >>> DW);
                        cq_reg <= OUT_BITS'(sq_reg) - OUT_BITS'(dc_sum_q_reg >>> DW);
                    end
                    thr8_reg <= (ASB+8)'((amp_sum_n >> AW) * thresh_frac);
                    st_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    st_reg <= ST_IDLE;
                    if (gate_open_reg)
                    begin
                        sample_count_reg <= sc_inc;
                        emit_last_reg <= (sc_inc >= ungate_target_reg);
                        if (sc_inc >= ungate_target_reg) gate_open_reg <= 1'b0;
                        st_reg <= ST_OUT;
                    end
                    else
                    begin
                        logic [15:0] sc;
                        logic [7:0]  pc;
                        logic        lh;
                        sc = sc_inc; pc = pulse_count_reg; lh = level_high_reg;
                        if (a8 < thr8_reg && lh)
                        begin
                            sc = '0; lh = 1'b0;
                        end
                        else if (a8 > thr8_reg && !lh)
                        begin
                            lh = 1'b1;
                            if (sc > 16'(pulse_width_samples >> 1))
                                pc = (pc == 8'hFF) ? pc : pc + 8'd1;
                            else
                                pc = '0;
                            sc = '0;
                        end
                        level_high_reg <= lh;
                        if (sc > t1_samples && lh && pc > min_pulses)
                        begin
                            gate_open_reg <= 1'b1;
                            pulse_count_reg <= '0;
                            sample_count_reg <= 16'd1;
                            emit_last_reg <= 1'b0;
                            st_reg <= ST_OUT;
                        end
                        else
                        begin
                            pulse_count_reg <= pc;
                            sample_count_reg <= sc;
                        end
                    end
                end
                ST_OUT:
                begin
                    // wait for a free result register
                    if (!ov_reg || out_ready)
                    begin
                        oi_reg <= ci_reg;
                        oq_reg <= cq_reg;
                        om_reg <= MAG_BITS'(34'($signed(ci_reg) * $signed(ci_reg))
                                          + 34'($signed(cq_reg) * $signed(cq_reg)));
                        ol_reg <= emit_last_reg;
                        ov_reg <= 1'b1;
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hdl/rfid_reply_gate_unit.sv
// Top level of the RFID reply gate.
// Usage:
//   s_axis_* carries requests: op selects a sample or a seek; sample_i/q are
//   the I/Q sample. m_axis_* carries gated, DC-corrected samples with their
//   squared magnitude; tlast marks the end of the gated burst.
//   cfg_we/cfg_idx/cfg_data write the seven registers; write only while idle.
// Sequencing:
//   A sample holds the back end for a pop, a squaring step, 17 bit-serial
//   square-root steps and a capture, a ring read, an update, a decision and
//   an output load; the output load is skipped when the sample gives no
//   result. A seek is handled in the idle state alone. A two-entry queue
//   lets the front take new requests while the back works.
// Reset:
//   rst_n clears counters, sums, ring fill counts and gate state; rings read
//   as zero until filled once. Registers return to their defaults.
// Stall:
//   When m_axis_tready is low the result is held; the back end waits, the
//   queue fills, then s_axis_tready drops.
`default_nettype none
module rfid_reply_gate_unit
    import rrg_pkg::*;
#(
    parameter int AMP_WIN     = AMP_WIN_DEF,
    parameter int DC_WIN      = DC_WIN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [IN_TDATA_BITS-1:0]     s_axis_tdata,  // sample_i, sample_q
    input  wire logic [1:0]                   s_axis_tuser,  // op
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0]         m_axis_tdata,  // out_i, out_q, magn_sq, pad
    output logic                              m_axis_tlast,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]      cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0]     cfg_data
);
    logic        enable_reg;
    logic [15:0] t1_reg, rn16_reg, epc_reg;
    logic [11:0] pw_reg;
    logic [7:0]  thr_reg, minp_reg;

    // Hold the configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1; t1_reg <= 16'd100; pw_reg <= 12'd24; thr_reg <= 8'd192;
            minp_reg <= 8'd4; rn16_reg <= 16'd1000; epc_reg <= 16'd5000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_T1:     t1_reg     <= cfg_data;
                REG_PW:     pw_reg     <= cfg_data[11:0];
                REG_THR:    thr_reg    <= cfg_data[7:0];
                REG_MINP:   minp_reg   <= cfg_data[7:0];
                REG_RN16:   rn16_reg   <= cfg_data;
                REG_EPC:    epc_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    logic     q_valid, q_pop;
    rrg_cmd_t q_head;
    logic signed [OUT_BITS-1:0] oi, oq;
    logic [MAG_BITS-1:0] om;

    // Classify and queue requests.
    rrg_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_op(s_axis_tuser), .in_i(s_axis_tdata[15:0]), .in_q(s_axis_tdata[31:16]),
        .enable(enable_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
    );

    // Carry out samples and seeks.
    rrg_back #(.AMP_WIN(AMP_WIN), .DC_WIN(DC_WIN)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
        .t1_samples(t1_reg), .pulse_width_samples(pw_reg), .thresh_frac(thr_reg),
        .min_pulses(minp_reg), .rn16_window_samples(rn16_reg),
        .epc_window_samples(epc_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_i(oi), .out_q(oq), .magn_sq(om), .last(m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, om, oq, oi};
endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench for rfid_reply_gate_unit: a stream driver, a result monitor and a gate predictor.
`default_nettype none
module tb;
    import rrg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]         op;
        logic signed [15:0] si;
        logic signed [15:0] sq;
    } request_t;

    typedef struct {
        logic [16:0] ci;
        logic [16:0] cq;
        logic [32:0] magn;
        logic        last;
    } gated_sample_t;

    localparam int IDLE_LIMIT  = 5000;
    localparam int SETTLE_CYC  = 128;
    localparam int HOLD_CYC    = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_BITS-1:0] s_axis_tdata = '0;   // sample_i, sample_q
    logic [1:0] s_axis_tuser = OP_SAMPLE;           // op
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;        // out_i, out_q, magn_sq, pad
    logic m_axis_tlast;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_idx = REG_ENABLE;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    rfid_reply_gate_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Request backlog and results still owed by the gate.
    request_t      pending_requests[$];
    gated_sample_t owed_samples[$];
    int  error_count = 0;
    int  queued_items = 0;
    bit  calm = 0;          // no idling in the last part of the run
    bit  hold_req = 0;      // ask the receiver for one long hold-off
    bit  in_fire = 0;
    int  idle_cycles = 0;

    // Gate settings as the predictor sees them.
    bit          g_enable;
    int unsigned g_t1, g_pw, g_frac, g_minp, g_rn16, g_epc;

    // Gate state.
    int unsigned amp_hist[64];
    int unsigned amp_total;
    int unsigned amp_idx;
    int          dc_hist_i[32];
    int          dc_hist_q[32];
    int          dc_total_i, dc_total_q;
    int unsigned dc_idx;
    int unsigned quiet_count;
    int unsigned pulse_tally;
    bit          level_up;
    bit          gate_is_open;
    int unsigned burst_target;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic owe_sample(input int si, input int sq, input bit last);
        gated_sample_t s;
        longint ci;
        longint cq;
        ci = longint'(si) - longint'(dc_total_i >>> 5);   // floor division by the DC window
        cq = longint'(sq) - longint'(dc_total_q >>> 5);
        s.ci = ci[16:0];
        s.cq = cq[16:0];
        s.magn = 33'(ci * ci + cq * cq);
        s.last = last;
        owed_samples = {owed_samples, s};
    endtask

    task automatic clear_gate_state();
        foreach (amp_hist[k]) amp_hist[k] = 0;
        foreach (dc_hist_i[k]) begin
            dc_hist_i[k] = 0;
            dc_hist_q[k] = 0;
        end
        amp_total = 0; amp_idx = 0;
        dc_total_i = 0; dc_total_q = 0; dc_idx = 0;
        quiet_count = 0; pulse_tally = 0;
        level_up = 0; gate_is_open = 0; burst_target = 0;
        g_enable = 1; g_t1 = 100; g_pw = 24; g_frac = 192;
        g_minp = 4; g_rn16 = 1000; g_epc = 5000;
    endtask

    // Advance the gate model by one accepted request.
    task automatic gate_step(input logic [1:0] op, input logic signed [15:0] i16,
                             input logic signed [15:0] q16);
        int si;
        int sq;
        int unsigned ampl;
        longint unsigned thr8;
        longint unsigned a8;
        if (op == OP_SEEK_RN || op == OP_SEEK_EPC) begin
            gate_is_open = 0;
            burst_target = (op == OP_SEEK_RN) ? g_rn16 : g_epc;
            quiet_count = 0;
            return;
        end
        if (op != OP_SAMPLE || !g_enable) return;
        si = i16;
        sq = q16;
        ampl = int_sqrt(longint'(si) * si + longint'(sq) * sq);
        amp_total = amp_total - amp_hist[amp_idx] + ampl;
        amp_hist[amp_idx] = ampl;
        amp_idx = (amp_idx + 1) % 64;
        thr8 = longint'(amp_total / 64) * g_frac;
        a8 = longint'(ampl) << 8;

        if (gate_is_open) begin
            if (quiet_count < 16'hFFFF) quiet_count++;
            if (quiet_count >= burst_target) begin
                gate_is_open = 0;
                owe_sample(si, sq, 1'b1);
            end else begin
                owe_sample(si, sq, 1'b0);
            end
            return;
        end

        dc_total_i = dc_total_i - dc_hist_i[dc_idx] + si;
        dc_total_q = dc_total_q - dc_hist_q[dc_idx] + sq;
        dc_hist_i[dc_idx] = si;
        dc_hist_q[dc_idx] = sq;
        dc_idx = (dc_idx + 1) % 32;
        if (quiet_count < 16'hFFFF) quiet_count++;

        if (a8 < thr8 && level_up) begin
            quiet_count = 0;
            level_up = 0;
        end else if (a8 > thr8 && !level_up) begin
            level_up = 1;
            if (quiet_count > (g_pw >> 1)) begin
                if (pulse_tally < 255) pulse_tally++;
            end else begin
                pulse_tally = 0;
            end
            quiet_count = 0;
        end

        if (quiet_count > g_t1 && level_up && pulse_tally > g_minp) begin
            gate_is_open = 1;
            owe_sample(si, sq, 1'b0);
            pulse_tally = 0;
            quiet_count = 1;
        end
    endtask

    // Input side: take the request at the rising edge, feed the gate model.
    always @(posedge clk) begin
        in_fire = s_axis_tvalid && s_axis_tready;
        if (in_fire)
            gate_step(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16]);
    end

    // Output side: check each gated sample against the oldest one owed.
    always @(posedge clk) begin
        gated_sample_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (owed_samples.size() == 0) begin
                report_mismatch("unexpected sample, out_i", m_axis_tdata[16:0], 0);
            end else begin
                want = owed_samples.pop_front();
                if (m_axis_tdata[16:0] !== want.ci)
                    report_mismatch("out_i", m_axis_tdata[16:0], want.ci);
                if (m_axis_tdata[33:17] !== want.cq)
                    report_mismatch("out_q", m_axis_tdata[33:17], want.cq);
                if (m_axis_tdata[66:34] !== want.magn)
                    report_mismatch("magn_sq", m_axis_tdata[66:34], want.magn);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", m_axis_tlast, want.last);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("rfid_reply_gate_unit test failed");
            $finish;
        end
    end

    // Driver: present the next request, with random bursts of idling.
    int send_gap = 0;
    always @(negedge clk) begin
        request_t r;
        if (rst_n && (!s_axis_tvalid || in_fire)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 15);
                s_axis_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                r = pending_requests.pop_front();
                s_axis_tuser <= r.op;
                s_axis_tdata <= {r.sq, r.si};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off once results are flowing.
    int recv_gap = 0;
    int hold_left = 0;
    bit hold_done = 0;
    always @(negedge clk) begin
        bit ready_next;
        if (rst_n) begin
            if (hold_req && !hold_done && m_axis_tvalid) begin
                hold_done = 1;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                ready_next = 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(0, 15);
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_axis_tready <= ready_next;
        end
    end

    task automatic queue_request(input logic [1:0] op, input int si, input int sq);
        request_t r;
        r.op = op;
        r.si = 16'(si);
        r.sq = 16'(sq);
        pending_requests = {pending_requests, r};
        queued_items++;
    endtask

    task automatic queue_quiet_sample();
        queue_request(OP_SAMPLE, $signed($urandom_range(0, 600)) - 300,
                      $signed($urandom_range(0, 600)) - 300);
    endtask

    task automatic queue_strong_sample();
        int a;
        a = $urandom_range(18000, 32767);
        queue_request(OP_SAMPLE, $urandom_range(0, 1) ? a : -a,
                      $signed($urandom_range(0, 16000)) - 8000);
    endtask

    // A seek, a train of reader pulses, each a quiet run then a strong run, and a strong tail for the reply window.
    task automatic queue_reply_burst();
        int n_pulses;
        int low_len;
        int tail;
        queue_request($urandom_range(0, 1) ? OP_SEEK_RN : OP_SEEK_EPC, $urandom, $urandom);
        n_pulses = (g_minp < 8) ? g_minp + 1 + $urandom_range(0, 2) : 3;
        for (int p = 0; p < n_pulses; p++) begin
            low_len = (g_pw >> 1) + 1 + $urandom_range(0, 3);
            if (low_len > 40) low_len = 40;
            repeat (low_len) queue_quiet_sample();
            repeat ($urandom_range(2, 6)) queue_strong_sample();
        end
        tail = ((g_t1 < 40) ? g_t1 : 20) + 2 + $urandom_range(0, 25);
        repeat (tail) queue_strong_sample();
    endtask

    task automatic queue_noise(input int n);
        repeat (n) queue_request(2'($urandom_range(0, 3)), $urandom, $urandom);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= 16'(val);
        case (idx)
            REG_ENABLE: g_enable = val[0];
            REG_T1:     g_t1 = val[15:0];
            REG_PW:     g_pw = val[11:0];
            REG_THR:    g_frac = val[7:0];
            REG_MINP:   g_minp = val[7:0];
            REG_RN16:   g_rn16 = val[15:0];
            REG_EPC:    g_epc = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input int unsigned en, t1, pw, frac, minp, rn, epc);
        write_reg(REG_ENABLE, en);
        write_reg(REG_T1, t1);
        write_reg(REG_PW, pw);
        write_reg(REG_THR, frac);
        write_reg(REG_MINP, minp);
        write_reg(REG_RN16, rn);
        write_reg(REG_EPC, epc);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every request is taken and every sample has come back.
    task automatic drain();
        while (pending_requests.size() != 0 || s_axis_tvalid) @(posedge clk);
        while (owed_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    initial begin
        int p;
        clear_gate_state();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, samples, seeks, undefined op, short targets.
        write_all(1, 2, 4, 192, 1, 0, 1);
        queue_request(OP_SAMPLE, -32768, -32768);
        queue_request(OP_SAMPLE, 32767, 32767);
        queue_request(OP_SAMPLE, 0, 0);
        queue_request(OP_SAMPLE, -32768, 32767);
        queue_request(2'd3, 32767, -32768);
        queue_request(OP_SEEK_EPC, 0, 0);
        queue_reply_burst();
        drain();

        // Disabled gate drops samples, but seeks still act.
        write_all(0, 3, 6, 160, 2, 5, 9);
        queue_request(OP_SAMPLE, 32767, -32768);
        queue_request(OP_SEEK_RN, 0, 0);
        queue_reply_burst();
        drain();

        // Random phases over a spread of settings, extremes among them.
        p = 0;
        while (p < 7 || queued_items < 600) begin
            int unsigned t1, pw, frac, minp, rn, epc;
            t1   = (p == 1) ? 65535 : (p == 2) ? 0 : $urandom_range(0, 12);
            pw   = (p == 2) ? 0 : (p == 3) ? 4095 : $urandom_range(0, 10);
            frac = (p == 2) ? 0 : (p == 4) ? 255 : $urandom_range(100, 230);
            minp = (p == 3) ? 255 : (p == 4) ? 0 : $urandom_range(0, 3);
            rn   = (p == 2) ? 0 : (p == 4) ? 65535 : $urandom_range(0, 20);
            epc  = (p == 2) ? 1 : (p == 4) ? 65535 : $urandom_range(0, 20);
            write_all((p == 5) ? 0 : 1, t1, pw, frac, minp, rn, epc);
            if (queued_items > 500) calm = 1;
            if (p == 0) hold_req = 1;   // back up the gate while requests keep coming
            if ($urandom_range(0, 4) == 0) queue_noise($urandom_range(3, 12));
            else queue_reply_burst();
            drain();
            p++;
        end

        if (error_count == 0)
            $display("rfid_reply_gate_unit test passed");
        else
            $display("rfid_reply_gate_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire
